// ===== rtl/thd_pkg.sv =====
// Shared types and constants for the tuple hash digest unit.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package thd_pkg;

    // Input operation codes
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // SplitMix64 constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_ONE  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_TWO  = 64'h94d049bb133111eb;
    localparam logic [63:0] COUNT_SALT   = 64'hd1b54a32d192ed03;

    // Job queue between front and back (depth must be a power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One input beat
    typedef struct packed {
        logic        op;
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [31:0] key_c;
        logic [31:0] key_d;
        logic [31:0] count;
    } thd_in_t;

    // One result beat
    typedef struct packed {
        logic [63:0] record_hash;
        logic [63:0] record_total;
        logic [63:0] weight_total;
        logic [63:0] hash_sum;
        logic [63:0] hash_xor;
        logic [63:0] hash_square_sum;
    } thd_out_t;

    // Classified job as held in the queue
    typedef struct packed {
        logic        is_clear;
        logic [63:0] pair_ab;
        logic [63:0] pair_cd;
        logic [63:0] count_word;
        logic [31:0] weight;
    } thd_job_t;

    // Multiplier request and response
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } thd_mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } thd_mul_rsp_t;

endpackage

// ===== rtl/thd_mul.sv =====
// Iterative 64x64 multiplier returning the low 64 bits.
// Uses one 32x32 multiplier over three products; depends on thd_pkg.
`timescale 1ns / 1ps

module thd_mul
    import thd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  thd_mul_req_t req,
    output thd_mul_rsp_t rsp
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] op_x, op_y;

    // operand select: al*bl, al*bh, ah*bl
    always_comb
    begin
        op_x = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        op_y = (step_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    end

    // step sequencing and partial product accumulation
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = op_x * op_y;
            unique case (step_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = prod_reg;
                2'd2: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                2'd3: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                default: acc_next = acc_reg;
            endcase
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== rtl/thd_front.sv =====
// Front end: accepts input beats, classifies them into jobs and queues them.
// Depends on thd_pkg.
`timescale 1ns / 1ps

module thd_front
    import thd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  thd_in_t  item,
    output logic     full,
    output logic     job_valid,
    output thd_job_t job,
    input  logic     job_pop
);

    thd_job_t          entries_reg [QDEPTH];
    thd_job_t          classified;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    // classify and pre-pack the hash operands
    always_comb
    begin
        classified.is_clear   = (item.op == OP_CLEAR);
        classified.pair_ab    = {item.key_b, item.key_a};
        classified.pair_cd    = {item.key_d, item.key_c};
        classified.count_word = {32'd0, item.count} | COUNT_SALT;
        classified.weight     = item.count;
    end

    // queue handshakes
    assign full      = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign job_valid = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = job_pop && job_valid;
    assign job       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= classified;
    end

endmodule

// ===== rtl/thd_back.sv =====
// Back end: sequences the SplitMix64 rounds on the shared multiplier,
// updates the running digest and holds the result beat. Depends on thd_pkg.
`timescale 1ns / 1ps

module thd_back
    import thd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_data,
    input  logic         job_valid,
    input  thd_job_t     job,
    output logic         job_pop,
    output thd_mul_req_t mul_req,
    input  thd_mul_rsp_t mul_rsp,
    output logic         empty,
    input  logic         pop,
    output thd_out_t     result
);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_M1S  = 4'd2;
    localparam logic [3:0] ST_M1W  = 4'd3;
    localparam logic [3:0] ST_M2S  = 4'd4;
    localparam logic [3:0] ST_M2W  = 4'd5;
    localparam logic [3:0] ST_SQS  = 4'd6;
    localparam logic [3:0] ST_SQW  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    // hash operand sources, in mixing order
    localparam logic [2:0] SRC_TAG  = 3'd0;
    localparam logic [2:0] SRC_AB   = 3'd1;
    localparam logic [2:0] SRC_CD   = 3'd2;
    localparam logic [2:0] SRC_CNT  = 3'd3;
    localparam logic [2:0] SRC_FOLD = 3'd4;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  src_reg, src_next;
    logic [63:0] tag_reg;
    thd_job_t    job_reg, job_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] fold_reg, fold_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] sq_reg, sq_next;
    logic [63:0] rec_acc_reg, rec_acc_next;
    logic [63:0] wgt_acc_reg, wgt_acc_next;
    logic [63:0] sum_acc_reg, sum_acc_next;
    logic [63:0] xor_acc_reg, xor_acc_next;
    logic [63:0] sqr_acc_reg, sqr_acc_next;
    logic        res_valid_reg, res_valid_next;
    thd_out_t    res_reg, res_next;
    logic [63:0] src_word, pre_sum, mul_out;
    logic        slot_free;

    // operand for the next mix round
    always_comb
    begin
        unique case (src_reg)
            SRC_TAG:  src_word = tag_reg;
            SRC_AB:   src_word = job_reg.pair_ab;
            SRC_CD:   src_word = job_reg.pair_cd;
            SRC_CNT:  src_word = job_reg.count_word;
            SRC_FOLD: src_word = fold_reg;
            default:  src_word = fold_reg;
        endcase
        pre_sum = src_word + GOLDEN_GAMMA;
    end

    assign mul_out   = mul_rsp.product;
    assign slot_free = !res_valid_reg || pop;

    // multiplier requests
    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = v_reg;
        mul_req.b     = MIX_MUL_ONE;
        unique case (state_reg)
            ST_M1S:
            begin
                mul_req.start = 1'b1;
            end
            ST_M2S:
            begin
                mul_req.start = 1'b1;
                mul_req.b     = MIX_MUL_TWO;
            end
            ST_SQS:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = h_reg;
                mul_req.b     = h_reg;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // sequencer and digest update
    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        job_next       = job_reg;
        v_next         = v_reg;
        fold_next      = fold_reg;
        h_next         = h_reg;
        sq_next        = sq_reg;
        rec_acc_next   = rec_acc_reg;
        wgt_acc_next   = wgt_acc_reg;
        sum_acc_next   = sum_acc_reg;
        xor_acc_next   = xor_acc_reg;
        sqr_acc_next   = sqr_acc_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        job_pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    job_next  = job;
                    src_next  = SRC_TAG;
                    fold_next = '0;
                    h_next    = '0;
                    sq_next   = '0;
                    state_next = job.is_clear ? ST_DONE : ST_PREP;
                end
            end
            ST_PREP:
            begin
                v_next     = pre_sum ^ (pre_sum >> 30);
                state_next = ST_M1S;
            end
            ST_M1S:
            begin
                state_next = ST_M1W;
            end
            ST_M1W:
            begin
                if (mul_rsp.done)
                begin
                    v_next     = mul_out ^ (mul_out >> 27);
                    state_next = ST_M2S;
                end
            end
            ST_M2S:
            begin
                state_next = ST_M2W;
            end
            ST_M2W:
            begin
                if (mul_rsp.done)
                begin
                    if (src_reg == SRC_FOLD)
                    begin
                        h_next     = mul_out ^ (mul_out >> 31);
                        state_next = ST_SQS;
                    end
                    else
                    begin
                        fold_next  = fold_reg ^ mul_out ^ (mul_out >> 31);
                        src_next   = src_reg + 3'd1;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_SQS:
            begin
                state_next = ST_SQW;
            end
            ST_SQW:
            begin
                if (mul_rsp.done)
                begin
                    sq_next    = mul_out;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    if (job_reg.is_clear)
                    begin
                        rec_acc_next = '0;
                        wgt_acc_next = '0;
                        sum_acc_next = '0;
                        xor_acc_next = '0;
                        sqr_acc_next = '0;
                    end
                    else
                    begin
                        rec_acc_next = rec_acc_reg + 64'd1;
                        wgt_acc_next = wgt_acc_reg + {32'd0, job_reg.weight};
                        sum_acc_next = sum_acc_reg + h_reg;
                        xor_acc_next = xor_acc_reg ^ h_reg;
                        sqr_acc_next = sqr_acc_reg + sq_reg + GOLDEN_GAMMA;
                    end
                    res_next.record_hash     = h_reg;
                    res_next.record_total    = rec_acc_next;
                    res_next.weight_total    = wgt_acc_next;
                    res_next.hash_sum        = sum_acc_next;
                    res_next.hash_xor        = xor_acc_next;
                    res_next.hash_square_sum = sqr_acc_next;
                    res_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and digest state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            src_reg       <= SRC_TAG;
            tag_reg       <= '0;
            rec_acc_reg   <= '0;
            wgt_acc_reg   <= '0;
            sum_acc_reg   <= '0;
            xor_acc_reg   <= '0;
            sqr_acc_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            rec_acc_reg   <= rec_acc_next;
            wgt_acc_reg   <= wgt_acc_next;
            sum_acc_reg   <= sum_acc_next;
            xor_acc_reg   <= xor_acc_next;
            sqr_acc_reg   <= sqr_acc_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
                tag_reg <= cfg_data;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        v_reg    <= v_next;
        fold_reg <= fold_next;
        h_reg    <= h_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

// ===== rtl/tuple_hash_digest_unit.sv =====
// Top level of the tuple hash digest unit.
// Instantiates thd_front, thd_back and thd_mul; depends on thd_pkg.
`timescale 1ns / 1ps

// Hashes each record (four 32-bit keys and a count) with SplitMix64, seeded by
// the stage tag written through cfg_we/cfg_data, and returns one result beat
// per input beat with the record hash and the running digest (records, total
// count, hash sum, hash XOR, sum of squared hashes each plus GOLDEN_GAMMA). A
// clear beat zeroes the digest and returns an all-zero result. With the result
// slot free, empty falls once the digest is updated, and the engine takes the
// next queued beat straight away. One 32x32 multiplier is shared by all eleven
// 64-bit multiplies of a record, three products each. Each of the five mix
// rounds is an add/shift state, then two multiplies, each a request state and
// a wait for done; the square is one more such multiply, and the job is taken
// in the idle state and the digest updated in the done state. Two input beats
// queue ahead of the hash engine and one finished result waits on the result
// ports, so either side can stall without stopping the other. Write the tag
// only while the unit is idle.
module tuple_hash_digest_unit
    import thd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  thd_in_t     item,
    output logic        empty,
    input  logic        pop,
    output thd_out_t    result,
    input  logic        cfg_we,
    input  logic [63:0] cfg_data
);

    logic         job_valid;
    logic         job_pop;
    thd_job_t     job;
    thd_mul_req_t mul_req;
    thd_mul_rsp_t mul_rsp;

    thd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    thd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    thd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== rtl/thd_checker.sv =====
// Port-level checks for tuple_hash_digest_unit, attached by bind.
// Depends on thd_pkg.
`timescale 1ns / 1ps

module thd_checker
    import thd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     push,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input thd_out_t result
);

    // beats accepted but not yet delivered
    logic [3:0] pending_reg, pending_next;
    logic       in_beat, out_beat;

    assign in_beat  = push && !full;
    assign out_beat = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
            pending_next = pending_reg + 4'd1;
        else if (out_beat && !in_beat)
            pending_next = pending_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    // no result without an accepted input beat
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != 4'd0)
        else $error("result shown with nothing outstanding");

    // queue, engine and result slot bound the beats in flight
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("too many beats in flight");

    // a zero record count means a freshly cleared, all-zero digest
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.record_total == 64'd0 |->
            result.record_hash == 64'd0 && result.weight_total == 64'd0 &&
            result.hash_sum == 64'd0 && result.hash_xor == 64'd0 &&
            result.hash_square_sum == 64'd0)
        else $error("cleared digest not zero");

endmodule

bind tuple_hash_digest_unit thd_checker u_thd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
